[hw/rtl/jblf_pkg.sv]
// Shared types, constants and the exponent table function for the joint bilateral filter.
package jblf_pkg;

	// Field widths
	localparam int GL_W    = 11;
	localparam int GC_W    = 12;
	localparam int VAL_W   = 16;
	localparam int NCH     = 3;
	localparam int GUIDE_W = GL_W + 2 * GC_W;
	localparam int VALUE_W = NCH * VAL_W;

	// Register widths and APB port
	localparam int FW_W    = 11;
	localparam int FH_W    = 11;
	localparam int SS_W    = 16;
	localparam int RS_W    = 24;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	// Weight arithmetic
	localparam int CD_W      = 26;
	localparam int PROD_LO_W = 13;
	localparam int EXP_SHIFT = 24;
	localparam int WT_W      = 17;
	localparam int PRD_W     = WT_W + 1 + VAL_W;
	localparam int QB        = 16;
	localparam longint unsigned EXP_ONE   = 64'd65536;
	localparam longint unsigned EXP_RATIO = 64'd4034748382;
	localparam longint unsigned EXP_HALF  = 64'h8000_0000;

	typedef enum logic [1:0] {
		REG_WIDTH   = 2'd0,
		REG_HEIGHT  = 2'd1,
		REG_SPATIAL = 2'd2,
		REG_RANGE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [GL_W-1:0]         guide_light;
		logic signed [GC_W-1:0]  guide_green_red;
		logic signed [GC_W-1:0]  guide_blue_yellow;
		logic signed [VAL_W-1:0] value_first;
		logic signed [VAL_W-1:0] value_second;
		logic signed [VAL_W-1:0] value_third;
		logic                    flush;
	} pix_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_first;
		logic signed [VAL_W-1:0] out_second;
		logic signed [VAL_W-1:0] out_third;
		logic                    frame_last;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTRE,
		ST_TAPS,
		ST_DRAIN,
		ST_HAND
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} div_state_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic rd_centre;
		logic tap_issue;
		logic handoff;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic produce;
		logic tap_last;
		logic pipe_empty;
	} dp_stat_t;

	// Entry k of the exponent table: exp(-k/16) in Q16, rounded step by step
	function automatic logic [WT_W-1:0] exp_entry(input int k);
		longint unsigned t;
		t = EXP_ONE;
		for (int i = 1; i <= k; i++)
			t = (t * EXP_RATIO + EXP_HALF) >> 32;
		return t[WT_W-1:0];
	endfunction

endpackage

[hw/rtl/jblf_stream_if.sv]
// Valid/ready stream channel carrying one payload of type data_t.
interface jblf_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[hw/rtl/jblf_ctrl.sv]
// Controller state machine: accepts requests and sequences the window pass.
module jblf_ctrl import jblf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     div_idle,
	input  dp_stat_t stat,
	output logic     in_ready,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_n;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	// Next state and commands
	always_comb begin
		state_n  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && stat.produce)
					state_n = ST_CENTRE;
			end
			ST_CENTRE: begin
				cmd.rd_centre = 1'b1;
				state_n       = ST_TAPS;
			end
			ST_TAPS: begin
				cmd.tap_issue = 1'b1;
				if (stat.tap_last)
					state_n = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (stat.pipe_empty)
					state_n = ST_HAND;
			end
			ST_HAND: begin
				if (div_idle) begin
					cmd.handoff = 1'b1;
					state_n     = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

endmodule

[hw/rtl/jblf_dp.sv]
// Datapath: line stores, stream position, tap addressing, weight pipeline, accumulators.
module jblf_dp import jblf_pkg::*; #(
	parameter int WIN_RADIUS     = 2,
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_HEIGHT     = 1024,
	parameter int EXP_TABLE_SIZE = 256,
	parameter int ACC_W          = 39,
	parameter int WS_W           = 22
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dp_cmd_t                       cmd,
	output dp_stat_t                      stat,
	input  pix_t                          pix,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]  w,
	input  logic [$clog2(MAX_HEIGHT+1)-1:0] h,
	input  logic [SS_W-1:0]               ss,
	input  logic [RS_W-1:0]               rs,
	input  logic                          restart,
	output logic signed [ACC_W-1:0]       acc [NCH],
	output logic [WS_W-1:0]               wsum,
	output logic                          win_last
);

	localparam int SPAN  = 2 * WIN_RADIUS + 1;
	localparam int DEPTH = SPAN * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int PW    = $clog2(MAX_WIDTH * MAX_HEIGHT + WIN_RADIUS * MAX_WIDTH
		+ WIN_RADIUS + 1);
	localparam int UW    = $clog2(WIN_RADIUS + 1);
	localparam int SW    = UW + 1;
	localparam int D2W   = $clog2(2 * WIN_RADIUS * WIN_RADIUS + 1);
	localparam int STW   = SS_W + D2W;
	localparam int PL_W  = RS_W + PROD_LO_W;
	localparam int EW    = RS_W + CD_W + 1;
	localparam int KW    = $clog2(EXP_TABLE_SIZE);

	// Stream position and derived frame limits
	logic [PW-1:0] pos_q, total, delay;
	logic [AW-1:0] wa_q, ca_q;
	logic [CW-1:0] cc_q;
	logic [RW-1:0] cr_q;
	logic          in_frame, prod_pos, ignore, produce, last;

	assign total    = PW'(w) * PW'(h);
	assign delay    = PW'(WIN_RADIUS) * PW'(w) + PW'(WIN_RADIUS);
	assign in_frame = pos_q < total;
	assign prod_pos = (pos_q >= delay) && (pos_q < total + delay);
	assign ignore   = in_frame && pix.flush;
	assign produce  = prod_pos && !ignore;
	assign last     = produce && (WW'(cc_q) == w - WW'(1)) && (HW'(cr_q) == h - HW'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			wa_q  <= '0;
			ca_q  <= '0;
			cc_q  <= '0;
			cr_q  <= '0;
		end else if (restart || (cmd.accept && last)) begin
			pos_q <= '0;
			wa_q  <= '0;
			ca_q  <= '0;
			cc_q  <= '0;
			cr_q  <= '0;
		end else if (cmd.accept && !ignore) begin
			pos_q <= pos_q + PW'(1);
			wa_q  <= (wa_q == AW'(DEPTH - 1)) ? '0 : wa_q + AW'(1);
			if (produce) begin
				ca_q <= (ca_q == AW'(DEPTH - 1)) ? '0 : ca_q + AW'(1);
				if (WW'(cc_q) == w - WW'(1)) begin
					cc_q <= '0;
					cr_q <= cr_q + RW'(1);
				end else begin
					cc_q <= cc_q + CW'(1);
				end
			end
		end
	end

	// Window bounds, clipped at the frame edges
	logic [UW-1:0]   up, down, left, right;
	logic [HW-1:0]   rows_below;
	logic [WW-1:0]   cols_right;
	logic [AW+1:0]   start_diff;
	logic [AW-1:0]   start_addr;

	always_comb begin
		rows_below = h - HW'(1) - HW'(cr_q);
		cols_right = w - WW'(1) - WW'(cc_q);
		up    = (cr_q < WIN_RADIUS) ? UW'(cr_q) : UW'(WIN_RADIUS);
		left  = (cc_q < WIN_RADIUS) ? UW'(cc_q) : UW'(WIN_RADIUS);
		down  = (rows_below < WIN_RADIUS) ? UW'(rows_below) : UW'(WIN_RADIUS);
		right = (cols_right < WIN_RADIUS) ? UW'(cols_right) : UW'(WIN_RADIUS);
		start_diff = (AW+2)'(ca_q) - (AW+2)'(up) * (AW+2)'(w) - (AW+2)'(left);
		start_addr = start_diff[AW+1] ? AW'(start_diff + (AW+2)'(DEPTH)) : AW'(start_diff);
	end

	// Tap sequencer
	logic [UW-1:0]        left_q, right_q, down_q;
	logic signed [SW-1:0] dx_q, dy_q;
	logic [AW-1:0]        row_addr_q, tap_addr_q, win_ca_q, row_next;
	logic [AW:0]          row_sum;
	logic                 last_q, tap_end_row;

	assign row_sum     = (AW+1)'(row_addr_q) + (AW+1)'(w);
	assign row_next    = (row_sum >= (AW+1)'(DEPTH)) ? AW'(row_sum - (AW+1)'(DEPTH))
		: AW'(row_sum);
	assign tap_end_row = dx_q == $signed({1'b0, right_q});

	always_ff @(posedge clk) begin
		if (cmd.accept && produce) begin
			left_q     <= left;
			right_q    <= right;
			down_q     <= down;
			dx_q       <= -$signed({1'b0, left});
			dy_q       <= -$signed({1'b0, up});
			row_addr_q <= start_addr;
			tap_addr_q <= start_addr;
			win_ca_q   <= ca_q;
			last_q     <= last;
		end else if (cmd.tap_issue) begin
			if (tap_end_row) begin
				dx_q       <= -$signed({1'b0, left_q});
				dy_q       <= dy_q + SW'(1);
				row_addr_q <= row_next;
				tap_addr_q <= row_next;
			end else begin
				dx_q       <= dx_q + SW'(1);
				tap_addr_q <= (tap_addr_q == AW'(DEPTH - 1)) ? '0 : tap_addr_q + AW'(1);
			end
		end
	end

	// Line stores
	logic [GUIDE_W-1:0] guide_mem [DEPTH];
	logic [VALUE_W-1:0] value_mem [DEPTH];
	logic [GUIDE_W-1:0] g_s1, cg_q;
	logic [VALUE_W-1:0] val_s1;
	logic [AW-1:0]      rd_addr;
	logic               wr_en, rd_en;

	assign wr_en   = cmd.accept && in_frame && !pix.flush;
	assign rd_en   = cmd.rd_centre || cmd.tap_issue;
	assign rd_addr = cmd.rd_centre ? win_ca_q : tap_addr_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			guide_mem[wa_q] <= {pix.guide_blue_yellow, pix.guide_green_red, pix.guide_light};
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			value_mem[wa_q] <= {pix.value_third, pix.value_second, pix.value_first};
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			g_s1   <= guide_mem[rd_addr];
			val_s1 <= value_mem[rd_addr];
		end
	end

	// Pipeline valid bits
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, cen_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			v_s6   <= 1'b0;
			cen_s1 <= 1'b0;
		end else begin
			v_s1   <= cmd.tap_issue;
			cen_s1 <= cmd.rd_centre;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			v_s5   <= v_s4;
			v_s6   <= v_s5;
		end
	end

	// Stage 1: colour and spatial distances
	logic signed [SW-1:0]   dx_s1, dy_s1;
	logic signed [GC_W:0]   dl, da, db;
	logic signed [2*GC_W+1:0] sl, sa, sb;
	logic signed [2*SW-1:0] sx, sy;
	logic [CD_W-1:0]        cd2;
	logic [D2W-1:0]         d2;

	always_ff @(posedge clk) begin
		if (cmd.tap_issue) begin
			dx_s1 <= dx_q;
			dy_s1 <= dy_q;
		end
		if (cen_s1)
			cg_q <= g_s1;
	end

	always_comb begin
		dl  = $signed({2'b00, g_s1[GL_W-1:0]}) - $signed({2'b00, cg_q[GL_W-1:0]});
		da  = $signed({g_s1[GL_W+GC_W-1], g_s1[GL_W +: GC_W]})
			- $signed({cg_q[GL_W+GC_W-1], cg_q[GL_W +: GC_W]});
		db  = $signed({g_s1[GUIDE_W-1], g_s1[GL_W+GC_W +: GC_W]})
			- $signed({cg_q[GUIDE_W-1], cg_q[GL_W+GC_W +: GC_W]});
		sl  = dl * dl;
		sa  = da * da;
		sb  = db * db;
		cd2 = CD_W'($unsigned(sl) + $unsigned(sa) + $unsigned(sb));
		sx  = dx_s1 * dx_s1;
		sy  = dy_s1 * dy_s1;
		d2  = D2W'($unsigned(sx + sy));
	end

	// Stage 2: spatial term and colour distance
	logic [CD_W-1:0]    cd2_s2;
	logic [STW-1:0]     st_s2, st_s3;
	logic [VALUE_W-1:0] val_s2, val_s3, val_s4, val_s5;

	always_ff @(posedge clk) begin
		cd2_s2 <= cd2;
		st_s2  <= STW'(ss) * STW'(d2);
		val_s2 <= val_s1;
	end

	// Stage 3: range term as two partial products
	logic [PL_W-1:0] plo_s3, phi_s3;

	always_ff @(posedge clk) begin
		plo_s3 <= PL_W'(rs) * PL_W'(cd2_s2[PROD_LO_W-1:0]);
		phi_s3 <= PL_W'(rs) * PL_W'(cd2_s2[CD_W-1:PROD_LO_W]);
		st_s3  <= st_s2;
		val_s3 <= val_s2;
	end

	// Stage 4: exponent sum, table index and range check
	logic [EW-1:0] e;
	logic [KW-1:0] k_s4;
	logic          hit_s4;

	assign e = (EW'(phi_s3) << PROD_LO_W) + EW'(plo_s3) + (EW'(st_s3) << 16);

	always_ff @(posedge clk) begin
		k_s4   <= e[EXP_SHIFT +: KW];
		hit_s4 <= (e >> EXP_SHIFT) < EW'(EXP_TABLE_SIZE);
		val_s4 <= val_s3;
	end

	// Exponent table
	logic [WT_W-1:0] exp_tab [EXP_TABLE_SIZE];

	for (genvar gi = 0; gi < EXP_TABLE_SIZE; gi++) begin : g_exp
		assign exp_tab[gi] = exp_entry(gi);
	end

	// Stage 5: weight
	logic [WT_W-1:0] wt_s5, wt_s6;

	always_ff @(posedge clk) begin
		wt_s5  <= hit_s4 ? exp_tab[k_s4] : '0;
		val_s5 <= val_s4;
	end

	// Stage 6: weighted values
	logic signed [PRD_W-1:0] prod_s6 [NCH];

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < NCH; ch++)
			prod_s6[ch] <= $signed({1'b0, wt_s5}) * $signed(val_s5[ch*VAL_W +: VAL_W]);
		wt_s6 <= wt_s5;
	end

	// Accumulators
	logic signed [ACC_W-1:0] acc_q [NCH];
	logic [WS_W-1:0]         wsum_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_centre) begin
			for (int ch = 0; ch < NCH; ch++)
				acc_q[ch] <= '0;
			wsum_q <= '0;
		end else if (v_s6) begin
			for (int ch = 0; ch < NCH; ch++)
				acc_q[ch] <= acc_q[ch] + ACC_W'(prod_s6[ch]);
			wsum_q <= wsum_q + WS_W'(wt_s6);
		end
	end

	assign acc      = acc_q;
	assign wsum     = wsum_q;
	assign win_last = last_q;

	assign stat.produce    = produce;
	assign stat.tap_last   = tap_end_row && (dy_q == $signed({1'b0, down_q}));
	assign stat.pipe_empty = !(v_s1 || v_s2 || v_s3 || v_s4 || v_s5 || v_s6);

	// New requests only land on an empty weight pipeline
	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |-> stat.pipe_empty)
		else $error("request accepted with taps in flight");

	// Tap addresses stay inside the line stores
	a_tap_addr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_issue |-> (tap_addr_q < AW'(DEPTH)) && (row_addr_q < AW'(DEPTH)))
		else $error("tap address outside line store");

	// A window is only opened on a centre inside the frame
	a_centre_in: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.accept && produce) |-> (WW'(cc_q) < w) && (HW'(cr_q) < h))
		else $error("centre outside frame");

endmodule

[hw/rtl/jblf_div.sv]
// Rounding divider lanes and output register for the filtered result.
module jblf_div import jblf_pkg::*; #(
	parameter int ACC_W = 39,
	parameter int WS_W  = 22
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic signed [ACC_W-1:0] acc [NCH],
	input  logic [WS_W-1:0]         wsum,
	input  logic                    last,
	output logic                    idle,
	jblf_stream_if.source           filtered
);

	localparam int CNT_W = $clog2(QB);

	div_state_t       state_q, state_n;
	logic [CNT_W-1:0] cnt_q;
	logic [WS_W-1:0]  den_q;
	logic [WS_W-1:0]  r_q   [NCH];
	logic [QB-1:0]    nlo_q [NCH];
	logic [QB-1:0]    q_q   [NCH];
	logic [NCH-1:0]   neg_q;
	logic             last_q;

	// State register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == DV_RUN)
				cnt_q <= cnt_q + CNT_W'(1);
			else
				cnt_q <= '0;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			DV_IDLE: if (load) state_n = DV_RUN;
			DV_RUN:  if (cnt_q == CNT_W'(QB - 1)) state_n = DV_DONE;
			DV_DONE: if (filtered.ready) state_n = DV_IDLE;
			default: state_n = DV_IDLE;
		endcase
	end

	// Load magnitude plus half divisor, then one quotient bit per cycle
	logic [ACC_W-1:0] mag [NCH];
	logic [ACC_W:0]   num [NCH];
	logic [WS_W:0]    trial [NCH];
	logic [NCH-1:0]   ge;

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			mag[ch]   = acc[ch][ACC_W-1] ? ACC_W'(-acc[ch]) : ACC_W'(acc[ch]);
			num[ch]   = (ACC_W+1)'(mag[ch]) + (ACC_W+1)'(wsum >> 1);
			trial[ch] = {r_q[ch], nlo_q[ch][QB-1]};
			ge[ch]    = trial[ch] >= {1'b0, den_q};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && load) begin
			den_q  <= wsum;
			last_q <= last;
			for (int ch = 0; ch < NCH; ch++) begin
				r_q[ch]   <= num[ch][QB +: WS_W];
				nlo_q[ch] <= num[ch][QB-1:0];
				q_q[ch]   <= '0;
				neg_q[ch] <= acc[ch][ACC_W-1];
			end
		end else if (state_q == DV_RUN) begin
			for (int ch = 0; ch < NCH; ch++) begin
				r_q[ch]   <= ge[ch] ? WS_W'(trial[ch] - {1'b0, den_q}) : WS_W'(trial[ch]);
				nlo_q[ch] <= nlo_q[ch] << 1;
				q_q[ch]   <= {q_q[ch][QB-2:0], ge[ch]};
			end
		end
	end

	// Sign, and saturation of positive quotients
	logic [VAL_W-1:0] res [NCH];

	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			if (neg_q[ch])
				res[ch] = VAL_W'(0) - q_q[ch];
			else if (q_q[ch][QB-1])
				res[ch] = {1'b0, {(VAL_W-1){1'b1}}};
			else
				res[ch] = q_q[ch];
		end
	end

	assign idle                       = state_q == DV_IDLE;
	assign filtered.valid             = state_q == DV_DONE;
	assign filtered.data.out_first    = res[0];
	assign filtered.data.out_second   = res[1];
	assign filtered.data.out_third    = res[2];
	assign filtered.data.frame_last   = last_q;

endmodule

[hw/rtl/joint_bilateral_lab_filter_unit.sv]
// Joint bilateral filter top level: APB registers, controller, datapath, divider.
// Pixels enter in raster order, each pairing a Lab guide pixel with a three-channel
// value pixel; a frame needs WIN_RADIUS*width + WIN_RADIUS flush requests after its
// last pixel to bring out the last results. A request that produces no result leaves
// the controller idle. A request that completes a centre pixel, when the divider is
// free, goes through accept, centre read, T window taps (up to (2*WIN_RADIUS+1)^2,
// 25 at the default radius, fewer at frame edges) read one per cycle from the line
// stores, a drain of the six-stage weight and multiply-accumulate pipeline, and a
// handoff to the divider. The rounding division of the three channels runs beside
// the next window, so a held output does not block input until the following window
// wants the divider.
// Registers (32-bit, at byte address 4*i): frame_width, frame_height, spatial_scale,
// range_scale; write them only while the block is idle. Writing a frame size
// restarts the frame.
module joint_bilateral_lab_filter_unit import jblf_pkg::*; #(
	parameter int WIN_RADIUS     = 2,
	parameter int MAX_WIDTH      = 1024,
	parameter int MAX_HEIGHT     = 1024,
	parameter int EXP_TABLE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	jblf_stream_if.sink        pixels,
	jblf_stream_if.source      filtered,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int SPAN  = 2 * WIN_RADIUS + 1;
	localparam int TAP_W = $clog2(SPAN * SPAN + 1);
	localparam int ACC_W = PRD_W + TAP_W;
	localparam int WS_W  = WT_W + TAP_W;
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);

	// Configuration registers
	logic [FW_W-1:0] fw_q;
	logic [FH_W-1:0] fh_q;
	logic [SS_W-1:0] ss_q;
	logic [RS_W-1:0] rs_q;
	logic            wr;
	reg_idx_t        idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;
	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FW_W'(640);
			fh_q <= FH_W'(480);
			ss_q <= SS_W'(256);
			rs_q <= RS_W'(4096);
		end else if (wr) begin
			unique case (idx)
				REG_WIDTH:   fw_q <= pwdata[FW_W-1:0];
				REG_HEIGHT:  fh_q <= pwdata[FH_W-1:0];
				REG_SPATIAL: ss_q <= pwdata[SS_W-1:0];
				REG_RANGE:   rs_q <= pwdata[RS_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (idx)
			REG_WIDTH:   prdata = PDATA_W'(fw_q);
			REG_HEIGHT:  prdata = PDATA_W'(fh_q);
			REG_SPATIAL: prdata = PDATA_W'(ss_q);
			REG_RANGE:   prdata = PDATA_W'(rs_q);
			default:     prdata = '0;
		endcase
	end

	// Frame size clamped to the supported range
	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic          restart;

	assign w_eff = (fw_q == '0) ? WW'(1) : (fw_q > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(fw_q);
	assign h_eff = (fh_q == '0) ? HW'(1) : (fh_q > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(fh_q);
	assign restart = wr && (idx == REG_WIDTH || idx == REG_HEIGHT);

	dp_cmd_t                 cmd;
	dp_stat_t                stat;
	logic                    in_ready, div_idle, win_last;
	logic signed [ACC_W-1:0] acc [NCH];
	logic [WS_W-1:0]         wsum;

	assign pixels.ready = in_ready;

	jblf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pixels.valid),
		.div_idle (div_idle),
		.stat     (stat),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	jblf_dp #(
		.WIN_RADIUS     (WIN_RADIUS),
		.MAX_WIDTH      (MAX_WIDTH),
		.MAX_HEIGHT     (MAX_HEIGHT),
		.EXP_TABLE_SIZE (EXP_TABLE_SIZE),
		.ACC_W          (ACC_W),
		.WS_W           (WS_W)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.pix      (pixels.data),
		.w        (w_eff),
		.h        (h_eff),
		.ss       (ss_q),
		.rs       (rs_q),
		.restart  (restart),
		.acc      (acc),
		.wsum     (wsum),
		.win_last (win_last)
	);

	jblf_div #(
		.ACC_W (ACC_W),
		.WS_W  (WS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (cmd.handoff),
		.acc      (acc),
		.wsum     (wsum),
		.last     (win_last),
		.idle     (div_idle),
		.filtered (filtered)
	);

endmodule

[bench/tb.sv]
// Self-checking bench for the joint bilateral Lab filter: random frames, prediction, compare.
`timescale 1ns / 100ps

module tb;
	import jblf_pkg::*;

	localparam int RADIUS     = 2;
	localparam int WIDTH_MAX  = 1024;
	localparam int HEIGHT_MAX = 1024;
	localparam int TABLE_LEN  = 256;
	localparam int STORE_LEN  = (2 * RADIUS + 1) * WIDTH_MAX;
	localparam int SETTLE     = 80;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	jblf_stream_if #(.data_t(pix_t)) pix_ch();
	jblf_stream_if #(.data_t(res_t)) res_ch();

	joint_bilateral_lab_filter_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.filtered(res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Predictor state: register copies, frame position, line stores, weight table
	logic [FW_W-1:0] cfg_width;
	logic [FH_W-1:0] cfg_height;
	logic [SS_W-1:0] cfg_spatial;
	logic [RS_W-1:0] cfg_range;
	int              col_pos;
	int              row_pos;
	pix_t            line_store[STORE_LEN];
	longint          weight_tab[TABLE_LEN];

	pix_t pending_pixels[$];
	res_t expected_pixels[$];
	int   mismatches;
	int   sent_items;
	int   src_idle;
	int   snk_idle;
	bit   src_hold;

	always #5 clk = ~clk;

	function automatic int clamp_dim(int v, int hi);
		if (v < 1) return 1;
		return (v > hi) ? hi : v;
	endfunction

	// Weighted mean of one window, rounded half away from zero
	function automatic logic [VAL_W-1:0] round_mean(longint num, longint den);
		longint q;
		if (num >= 0) q = (num + den / 2) / den;
		else q = -((-num + den / 2) / den);
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return q[VAL_W-1:0];
	endfunction

	// Apply one accepted request to the filter model
	task automatic filter_request(input pix_t p);
		int     w, h, tot, dly, pos, c, ci, cj, r0, r1, c0, c1, dx, dy;
		longint e, cd2, k, wt, wsum, dl, da, db;
		longint acc[3];
		pix_t   g0, g;
		res_t   r;
		bit     last;
		w   = clamp_dim(cfg_width, WIDTH_MAX);
		h   = clamp_dim(cfg_height, HEIGHT_MAX);
		tot = w * h;
		dly = RADIUS * w + RADIUS;
		pos = row_pos * w + col_pos;
		last = 0;
		if (pos < tot) begin
			if (p.flush) return;
			line_store[pos % STORE_LEN] = p;
		end
		if (pos >= dly && pos - dly < tot) begin
			c  = pos - dly;
			ci = c / w;
			cj = c % w;
			r0 = (ci >= RADIUS) ? ci - RADIUS : 0;
			r1 = (ci + RADIUS < h) ? ci + RADIUS : h - 1;
			c0 = (cj >= RADIUS) ? cj - RADIUS : 0;
			c1 = (cj + RADIUS < w) ? cj + RADIUS : w - 1;
			g0 = line_store[c % STORE_LEN];
			acc = '{0, 0, 0};
			wsum = 0;
			for (int ri = r0; ri <= r1; ri++) begin
				for (int cc = c0; cc <= c1; cc++) begin
					g  = line_store[(ri * w + cc) % STORE_LEN];
					dy = ri - ci;
					dx = cc - cj;
					dl = longint'(g.guide_light) - longint'(g0.guide_light);
					da = longint'($signed(g.guide_green_red))
					   - longint'($signed(g0.guide_green_red));
					db = longint'($signed(g.guide_blue_yellow))
					   - longint'($signed(g0.guide_blue_yellow));
					cd2 = dl * dl + da * da + db * db;
					e = ((longint'(cfg_spatial) * (dx * dx + dy * dy)) << 16)
					  + longint'(cfg_range) * cd2;
					k = e >>> 24;
					wt = (k < TABLE_LEN) ? weight_tab[k] : 0;
					wsum += wt;
					acc[0] += wt * longint'($signed(g.value_first));
					acc[1] += wt * longint'($signed(g.value_second));
					acc[2] += wt * longint'($signed(g.value_third));
				end
			end
			last = (c == tot - 1);
			r.out_first  = round_mean(acc[0], wsum);
			r.out_second = round_mean(acc[1], wsum);
			r.out_third  = round_mean(acc[2], wsum);
			r.frame_last = last;
			expected_pixels.push_back(r);
		end
		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end else begin
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
			end
		end
	endtask

	// APB write: setup then access; model follows at the access edge
	task automatic reg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'({idx, 2'b00});
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_WIDTH: begin
				cfg_width = val[FW_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_HEIGHT: begin
				cfg_height = val[FH_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			REG_SPATIAL: cfg_spatial = val[SS_W-1:0];
			REG_RANGE:   cfg_range = val[RS_W-1:0];
		endcase
	endtask

	task automatic program_all(input int w, input int h, input int ss, input int rs);
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_SPATIAL, ss);
		reg_write(REG_RANGE, rs);
	endtask

	// Guide pixel near a base colour, sometimes anywhere in range
	function automatic pix_t make_pixel(input pix_t base, input bit fl);
		pix_t p;
		int   l;
		if ($urandom_range(99) < 15) begin
			p.guide_light       = $urandom_range(1600);
			p.guide_green_red   = $urandom;
			p.guide_blue_yellow = $urandom;
		end else begin
			l = int'(base.guide_light) + $urandom_range(8) - 4;
			p.guide_light       = (l < 0) ? 0 : (l > 1600) ? 1600 : l;
			p.guide_green_red   = base.guide_green_red + $urandom_range(6) - 3;
			p.guide_blue_yellow = base.guide_blue_yellow + $urandom_range(6) - 3;
		end
		p.value_first  = $urandom;
		p.value_second = $urandom;
		p.value_third  = $urandom;
		p.flush        = fl;
		return p;
	endfunction

	// One frame in raster order with stray flushes, then, unless cut, the trailing items
	task automatic queue_frame(input int w, input int h, input bit cut);
		pix_t base;
		int   n;
		base = make_pixel('0, 1'b0);
		n = cut ? $urandom_range(w * h) : w * h;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(99) < 5) pending_pixels.push_back(make_pixel(base, 1'b1));
			pending_pixels.push_back(make_pixel(base, 1'b0));
		end
		if (!cut)
			for (int i = 0; i < RADIUS * w + RADIUS; i++)
				pending_pixels.push_back(make_pixel(base, $urandom_range(99) >= 10));
		sent_items += n + (cut ? 0 : RADIUS * w + RADIUS);
	endtask

	task automatic drain_all();
		wait (pending_pixels.size() == 0 && !pix_ch.valid && expected_pixels.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_ch.valid <= 1'b0;
		end else if (!pix_ch.valid || pix_ch.ready) begin
			if (pending_pixels.size() != 0 && !src_hold && $urandom_range(99) >= src_idle) begin
				pix_ch.valid <= 1'b1;
				pix_ch.data  <= pending_pixels.pop_front();
			end else begin
				pix_ch.valid <= 1'b0;
			end
		end
	end

	// Accepted requests feed the model
	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) filter_request(pix_ch.data);
	end

	// Result receiver with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_ch.ready <= 1'b0;
		else res_ch.ready <= ($urandom_range(99) >= snk_idle);
	end

	// Result checker
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got = res_ch.data;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", got);
			end else begin
				want = expected_pixels.pop_front();
				if (got.out_first !== want.out_first || got.out_second !== want.out_second
				    || got.out_third !== want.out_third || got.frame_last !== want.frame_last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result mismatch: expected %0d %0d %0d last %0b, got %0d %0d %0d last %0b",
						         want.out_first, want.out_second, want.out_third, want.frame_last,
						         got.out_first, got.out_second, got.out_third, got.frame_last);
				end
			end
		end
	end

	// Run limit
	initial begin
		#30ms;
		$display("Mismatches found");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		pix_t p;
		int   w, h, ss, rs;
		bit   held;
		clk = 0;
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		pix_ch.valid = 0;
		pix_ch.data = '0;
		res_ch.ready = 0;
		mismatches = 0;
		sent_items = 0;
		src_idle = 38;
		snk_idle = 54;
		src_hold = 0;
		held = 0;
		cfg_width = 640;
		cfg_height = 480;
		cfg_spatial = 256;
		cfg_range = 4096;
		col_pos = 0;
		row_pos = 0;
		weight_tab[0] = EXP_ONE;
		for (int k = 1; k < TABLE_LEN; k++)
			weight_tab[k] = longint'(($unsigned(weight_tab[k - 1]) * EXP_RATIO
			                          + EXP_HALF) >> 32);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: 3x2 frame with field extremes, then tiny sizes and scale extremes
		program_all(3, 2, 0, 0);
		for (int i = 0; i < 6; i++) begin
			p.guide_light       = (i % 2) ? 1600 : 0;
			p.guide_green_red   = (i % 3 == 0) ? -2048 : 2047;
			p.guide_blue_yellow = (i % 3 == 1) ? -2048 : 2047;
			p.value_first       = (i % 2) ? 16'sh7FFF : 16'sh8000;
			p.value_second      = (i < 3) ? 16'sh7FFF : 16'sh8000;
			p.value_third       = (i % 3) ? 16'sh8000 : 16'sh7FFF;
			p.flush             = 1'b0;
			if (i == 2) begin
				p.flush = 1'b1;
				pending_pixels.push_back(p);
				p.flush = 1'b0;
			end
			pending_pixels.push_back(p);
		end
		p.flush = 1'b0;
		for (int i = 0; i < RADIUS * 3 + RADIUS; i++) pending_pixels.push_back(p);
		sent_items += 15;
		drain_all();
		program_all(0, 0, 65535, 24'hFFFFFF);
		queue_frame(1, 1, 0);
		drain_all();
		program_all(1, 2, 256, 1);
		queue_frame(1, 2, 0);
		drain_all();

		// Random frames; idling pattern shifts by progress
		while (sent_items < 850) begin
			if (sent_items < 283) begin
				src_idle = 38;
				snk_idle = 54;
			end else if (sent_items < 566) begin
				src_idle = 54;
				snk_idle = 38;
			end else begin
				src_idle = 0;
				snk_idle = 0;
			end
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			ss = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2048);
			rs = ($urandom_range(5) == 0) ? $urandom_range(24'hFFFFFF) : $urandom_range(3000);
			program_all(w, h, ss, rs);
			queue_frame(w, h, $urandom_range(9) == 0);
			if ($urandom_range(1)) queue_frame(w, h, 0);
			// Once: hold the sender until every expected result is out
			if (!held && sent_items > 400) begin
				wait (pending_pixels.size() == 0);
				src_hold = 1;
				wait (expected_pixels.size() == 0);
				src_hold = 0;
				held = 1;
			end
			drain_all();
		end

		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
